FILE: rtl/pfd_pkg.sv
package pfd_pkg;

  localparam int GRID_SIDE  = 5;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int ALPHABET   = 26;
  localparam int LETTER_W   = 5;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(GRID_SIDE);

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CELL_W-1:0]   cell_t;
  typedef logic [ROW_W-1:0]    row_t;

  localparam letter_t CODE_I = 5'd8;
  localparam letter_t CODE_J = 5'd9;
  localparam letter_t CODE_Z = 5'd25;

  localparam logic [1:0] MODE_KEY     = 2'd0;
  localparam logic [1:0] MODE_FINISH  = 2'd1;
  localparam logic [1:0] MODE_DECRYPT = 2'd2;

  typedef enum logic [1:0] {
    OP_KEY,
    OP_FINISH,
    OP_DECRYPT
  } pfd_op_t;

  typedef struct packed {
    pfd_op_t op;
    letter_t first;
    letter_t second;
  } pfd_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FILL,
    BK_POS,
    BK_CELL
  } pfd_back_state_t;

  function automatic row_t cell_row(cell_t p);
    row_t r;
    r = '0;
    for (int i = 1; i < GRID_SIDE; i++) begin
      if (p >= CELL_W'(i * GRID_SIDE)) r = ROW_W'(i);
    end
    return r;
  endfunction

  function automatic row_t cell_col(cell_t p);
    cell_t t;
    t = p - CELL_W'(CELL_W'(cell_row(p)) * CELL_W'(GRID_SIDE));
    return ROW_W'(t);
  endfunction

  function automatic cell_t cell_index(row_t row, row_t col);
    return CELL_W'(CELL_W'(row) * CELL_W'(GRID_SIDE) + CELL_W'(col));
  endfunction

  // step back one place with wrap
  function automatic row_t wrap_dec(row_t v);
    return (v == '0) ? ROW_W'(GRID_SIDE - 1) : v - ROW_W'(1);
  endfunction

endpackage

FILE: rtl/playfair_decrypt_unit.sv
// Playfair decryption over a 5x5 key square. Send key letters (mode 0) to
// build the square, J counting as I and repeats skipped; a key letter after
// a finished square starts a new one. A finish item (mode 1) fills the rest
// of the alphabet without J. A decrypt item (mode 2) returns one plaintext
// pair, or not_ready with zero letters if the square is not finished yet;
// key, finish and unused mode 3 give no result. The front folds letters and
// takes one item a cycle into a short queue. The back retires a key letter,
// or a not-ready decrypt, as it takes it; a decrypt goes through a position
// table read, then a square read, each a registered memory read, then the
// output load, and a finish takes the item, then steps through the alphabet
// one letter a cycle. The result sits in an output register, so key and
// finish items go on while a result waits to be taken; a decrypt holds in
// the back until that register frees. The input stalls while the queue is
// full.
module playfair_decrypt_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [4:0] in_first_letter,
  input  logic [4:0] in_second_letter,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_plain_first,
  output logic [4:0] out_plain_second,
  output logic       out_not_ready
);
  import pfd_pkg::*;

  // front to queue
  logic       push;
  pfd_entry_t push_entry;
  logic       q_full;
  // queue to back
  logic       q_valid;
  pfd_entry_t q_entry;
  logic       q_pop;

  // classify and fold incoming items
  pfd_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_first_letter  (in_first_letter),
    .in_second_letter (in_second_letter),
    .q_full           (q_full),
    .q_push           (push),
    .q_entry          (push_entry)
  );

  // hold items while the back is busy with a fill or a lookup
  pfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop        (q_pop)
  );

  // square build, lookups and output register
  pfd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plain_first  (out_plain_first),
    .out_plain_second (out_plain_second),
    .out_not_ready    (out_not_ready)
  );

endmodule

FILE: rtl/pfd_queue.sv
module pfd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pfd_pkg::pfd_entry_t push_entry,
  output logic                full,
  output logic                pop_valid,
  output pfd_pkg::pfd_entry_t pop_entry,
  input  logic                pop
);
  import pfd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pfd_entry_t         slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

FILE: rtl/pfd_front.sv
module pfd_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  pfd_pkg::letter_t    in_first_letter,
  input  pfd_pkg::letter_t    in_second_letter,
  input  logic                q_full,
  output logic                q_push,
  output pfd_pkg::pfd_entry_t q_entry
);
  import pfd_pkg::*;

  // clamp out-of-range codes to Z, fold J onto I
  function automatic letter_t fold_letter(letter_t v);
    letter_t c;
    c = (v > CODE_Z) ? CODE_Z : v;
    if (c == CODE_J) c = CODE_I;
    return c;
  endfunction

  logic known;

  always_comb begin
    known      = 1'b1;
    q_entry.op = OP_KEY;
    case (in_mode)
      MODE_KEY:     q_entry.op = OP_KEY;
      MODE_FINISH:  q_entry.op = OP_FINISH;
      MODE_DECRYPT: q_entry.op = OP_DECRYPT;
      default:      known = 1'b0;
    endcase
    q_entry.first  = fold_letter(in_first_letter);
    q_entry.second = fold_letter(in_second_letter);
  end

  assign in_stall = q_full;
  // drop unused mode codes at the door
  assign q_push   = in_valid && !q_full && known;

endmodule

FILE: rtl/pfd_back.sv
module pfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  pfd_pkg::pfd_entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pfd_pkg::letter_t    out_plain_first,
  output pfd_pkg::letter_t    out_plain_second,
  output logic                out_not_ready
);
  import pfd_pkg::*;

  pfd_back_state_t     state_r, state_nxt;
  logic [ALPHABET-1:0] used_r, used_nxt, base_used;
  cell_t               fill_r, fill_nxt, base_fill;
  logic                complete_r, complete_nxt;
  letter_t             cnt_r, cnt_nxt;

  letter_t             sq_mem  [CELL_COUNT];
  cell_t               pos_mem [ALPHABET];
  cell_t               pos_a_q, pos_b_q;
  letter_t             cell_a_q, cell_b_q;
  cell_t               sq_raddr_a, sq_raddr_b;
  logic                pos_re, sq_re;

  logic                place_en, clear, place_ok;
  letter_t             place_letter;
  logic                res_load, res_nr;
  letter_t             res_a, res_b;

  logic                out_valid_r;
  letter_t             plain_first_r, plain_second_r;
  logic                not_ready_r;
  logic                out_free;

  row_t                ra, ca, rb, cb;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && q_entry.op == OP_FINISH) state_nxt = BK_FILL;
        else if (q_valid && q_entry.op == OP_DECRYPT && complete_r) state_nxt = BK_POS;
      end
      BK_FILL: if (cnt_r == LETTER_W'(ALPHABET - 1)) state_nxt = BK_IDLE;
      BK_POS:  state_nxt = BK_CELL;
      BK_CELL: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    place_en     = 1'b0;
    place_letter = q_entry.first;
    clear        = 1'b0;
    cnt_nxt      = cnt_r;
    complete_nxt = complete_r;
    res_load     = 1'b0;
    res_nr       = 1'b0;
    res_a        = '0;
    res_b        = '0;
    pos_re       = 1'b0;
    sq_re        = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pos_re = 1'b1;
        if (q_valid) begin
          case (q_entry.op)
            OP_KEY: begin
              q_pop    = 1'b1;
              clear    = complete_r;
              place_en = 1'b1;
            end
            OP_FINISH: begin
              q_pop   = 1'b1;
              cnt_nxt = '0;
            end
            OP_DECRYPT: begin
              if (complete_r) begin
                q_pop = 1'b1;
              end else if (out_free) begin
                q_pop    = 1'b1;
                res_load = 1'b1;
                res_nr   = 1'b1;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_FILL: begin
        place_en     = (cnt_r != CODE_J);
        place_letter = cnt_r;
        cnt_nxt      = cnt_r + LETTER_W'(1);
        if (cnt_r == LETTER_W'(ALPHABET - 1)) complete_nxt = 1'b1;
      end
      BK_POS: sq_re = 1'b1;
      BK_CELL: begin
        if (out_free) begin
          res_load = 1'b1;
          res_a    = cell_a_q;
          res_b    = cell_b_q;
        end
      end
      default: ;
    endcase

    // a key after a finished square starts over
    base_used = clear ? '0 : used_r;
    base_fill = clear ? '0 : fill_r;
    if (clear) complete_nxt = 1'b0;
    place_ok  = place_en && !base_used[place_letter] && (base_fill < CELL_W'(CELL_COUNT));
    used_nxt  = base_used;
    fill_nxt  = base_fill;
    if (place_ok) begin
      used_nxt[place_letter] = 1'b1;
      fill_nxt               = base_fill + CELL_W'(1);
    end
  end

  // cell addresses for the three pair rules
  always_comb begin
    ra = cell_row(pos_a_q);
    ca = cell_col(pos_a_q);
    rb = cell_row(pos_b_q);
    cb = cell_col(pos_b_q);
    if (ra == rb) begin
      sq_raddr_a = cell_index(ra, wrap_dec(ca));
      sq_raddr_b = cell_index(rb, wrap_dec(cb));
    end else if (ca == cb) begin
      sq_raddr_a = cell_index(wrap_dec(ra), ca);
      sq_raddr_b = cell_index(wrap_dec(rb), cb);
    end else begin
      sq_raddr_a = cell_index(ra, cb);
      sq_raddr_b = cell_index(rb, ca);
    end
  end

  always_ff @(posedge clk) begin
    if (place_ok) sq_mem[base_fill] <= place_letter;
    if (sq_re) begin
      cell_a_q <= sq_mem[sq_raddr_a];
      cell_b_q <= sq_mem[sq_raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (place_ok) pos_mem[place_letter] <= base_fill;
    if (pos_re) begin
      pos_a_q <= pos_mem[q_entry.first];
      pos_b_q <= pos_mem[q_entry.second];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      used_r      <= '0;
      fill_r      <= '0;
      complete_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      fill_r     <= fill_nxt;
      complete_r <= complete_nxt;
      cnt_r      <= cnt_nxt;
      if (res_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      plain_first_r  <= res_a;
      plain_second_r <= res_b;
      not_ready_r    <= res_nr;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_plain_first  = plain_first_r;
  assign out_plain_second = plain_second_r;
  assign out_not_ready    = not_ready_r;

endmodule

FILE: rtl/pfd_checker.sv
module pfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_mode,
  input logic [4:0] in_first_letter,
  input logic [4:0] in_second_letter,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] out_plain_first,
  input logic [4:0] out_plain_second,
  input logic       out_not_ready
);
  import pfd_pkg::*;

  // a stalled item holds its fields
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_mode)
      && $stable(in_first_letter) && $stable(in_second_letter))
    else $error("stalled item changed");

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_plain_first)
      && $stable(out_plain_second) && $stable(out_not_ready))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_not_ready |-> out_plain_first == '0 && out_plain_second == '0)
    else $error("not-ready result carries letters");

  // a finished square never holds J or a code past Z
  a_plain_letters: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_not_ready |->
      out_plain_first <= CODE_Z && out_plain_first != CODE_J
      && out_plain_second <= CODE_Z && out_plain_second != CODE_J)
    else $error("plaintext letter out of the square alphabet");

endmodule

bind playfair_decrypt_unit pfd_checker u_pfd_checker (.*);

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pfd_pkg::*;

  // Mode 3 has no name in the package; the block must ignore it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_PCT    = 19;
  localparam int ITEM_TARGET = 1450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    letter_t plain_first;
    letter_t plain_second;
    logic    not_ready;
  } plain_pair_t;

  // One row of the directed table. Rows with has_typed set carry a result
  // worked out by hand; all other decrypt rows are checked against the
  // square predictor below.
  typedef struct packed {
    logic [1:0]  mode;
    letter_t     first_letter;
    letter_t     second_letter;
    logic        has_typed;
    plain_pair_t typed_plain;
  } pair_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_mode = MODE_KEY;
  logic [4:0] in_first_letter = '0;
  logic [4:0] in_second_letter = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] out_plain_first;
  logic [4:0] out_plain_second;
  logic       out_not_ready;

  playfair_decrypt_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_first_letter  (in_first_letter),
    .in_second_letter (in_second_letter),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plain_first  (out_plain_first),
    .out_plain_second (out_plain_second),
    .out_not_ready    (out_not_ready)
  );

  always #6 clk = ~clk;

  // Directed part. The key PLAYFAIREXAMPLE (repeats dropped, J as I) gives
  //   P L A Y F / I R E X M / B C D G H / K N O Q S / T U V W Z
  // after the finish item; the classic pairs below go through the predictor.
  pair_row_t directed_rows [0:24] = '{
    {MODE_DECRYPT, 5'd0,  5'd0,  1'b1, 5'd0,  5'd0,  1'b1}, // decrypt right after reset
    {MODE_KEY,     5'd15, 5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // P
    {MODE_KEY,     5'd11, 5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // L
    {MODE_KEY,     5'd0,  5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // A
    {MODE_KEY,     5'd24, 5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // Y
    {MODE_KEY,     5'd5,  5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // F
    {MODE_KEY,     5'd0,  5'd31, 1'b0, 5'd0,  5'd0,  1'b0}, // A again, dropped
    {MODE_KEY,     5'd9,  5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // J lands as I
    {MODE_KEY,     5'd17, 5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // R
    {MODE_KEY,     5'd4,  5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // E
    {MODE_KEY,     5'd23, 5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // X
    {MODE_KEY,     5'd12, 5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // M
    {MODE_UNUSED,  5'd31, 5'd31, 1'b0, 5'd0,  5'd0,  1'b0}, // ignored mode
    {MODE_DECRYPT, 5'd31, 5'd31, 1'b1, 5'd0,  5'd0,  1'b1}, // square not finished
    {MODE_FINISH,  5'd0,  5'd0,  1'b0, 5'd0,  5'd0,  1'b0},
    {MODE_FINISH,  5'd31, 5'd31, 1'b0, 5'd0,  5'd0,  1'b0}, // finish again, no change
    {MODE_DECRYPT, 5'd1,  5'd12, 1'b0, 5'd0,  5'd0,  1'b0}, // rectangle BM -> HI
    {MODE_DECRYPT, 5'd11, 5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // same row LA -> PL
    {MODE_DECRYPT, 5'd17, 5'd2,  1'b0, 5'd0,  5'd0,  1'b0}, // same column RC -> LR
    {MODE_DECRYPT, 5'd9,  5'd1,  1'b0, 5'd0,  5'd0,  1'b0}, // ciphertext J as I
    {MODE_DECRYPT, 5'd31, 5'd30, 1'b0, 5'd0,  5'd0,  1'b0}, // codes above Z
    {MODE_DECRYPT, 5'd0,  5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // doubled letter
    {MODE_KEY,     5'd31, 5'd0,  1'b0, 5'd0,  5'd0,  1'b0}, // new key clears square
    {MODE_DECRYPT, 5'd0,  5'd0,  1'b1, 5'd0,  5'd0,  1'b1}, // not finished again
    {MODE_FINISH,  5'd0,  5'd0,  1'b0, 5'd0,  5'd0,  1'b0}
  };

  // Predicted key square, kept in step with every accepted item.
  letter_t             sq_cell [CELL_COUNT];
  cell_t               sq_pos  [ALPHABET];
  logic [ALPHABET-1:0] sq_used = '0;
  int                  sq_fill = 0;
  logic                sq_done = 1'b0;

  plain_pair_t expected_plain [$];
  int          items_sent = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  logic        src_gappy = 1'b1;
  logic        sink_gappy = 1'b1;

  // Saturate codes above Z, then read J as I.
  function automatic letter_t fold_code(logic [4:0] v);
    letter_t c;
    c = (v > CODE_Z) ? CODE_Z : v;
    if (c == CODE_J) c = CODE_I;
    return c;
  endfunction

  function automatic void add_to_square(letter_t c);
    if (sq_used[c] || sq_fill >= CELL_COUNT) return;
    sq_cell[sq_fill] = c;
    sq_pos[c] = cell_t'(sq_fill);
    sq_used[c] = 1'b1;
    sq_fill++;
  endfunction

  // Advance the predicted square by one item; return the plain pair that a
  // decrypt item gives.
  function automatic void step_square(input logic [1:0] m, input letter_t a,
                                      input letter_t b, output logic has_plain,
                                      output plain_pair_t plain);
    int pa, pb, ra, ca, rb, cb;
    has_plain = 1'b0;
    plain = '0;
    case (m)
      MODE_KEY: begin
        if (sq_done) begin
          sq_used = '0;
          sq_fill = 0;
          sq_done = 1'b0;
        end
        add_to_square(fold_code(a));
      end
      MODE_FINISH: begin
        for (int c = 0; c < ALPHABET; c++) begin
          if (letter_t'(c) != CODE_J) add_to_square(letter_t'(c));
        end
        sq_done = 1'b1;
      end
      MODE_DECRYPT: begin
        has_plain = 1'b1;
        if (!sq_done) begin
          plain.not_ready = 1'b1;
        end else begin
          pa = int'(sq_pos[fold_code(a)]);
          pb = int'(sq_pos[fold_code(b)]);
          ra = pa / GRID_SIDE;
          ca = pa % GRID_SIDE;
          rb = pb / GRID_SIDE;
          cb = pb % GRID_SIDE;
          if (ra == rb) begin
            // same row: step left with wrap
            plain.plain_first  = sq_cell[ra * GRID_SIDE + (ca + GRID_SIDE - 1) % GRID_SIDE];
            plain.plain_second = sq_cell[rb * GRID_SIDE + (cb + GRID_SIDE - 1) % GRID_SIDE];
          end else if (ca == cb) begin
            // same column: step up with wrap
            plain.plain_first  = sq_cell[((ra + GRID_SIDE - 1) % GRID_SIDE) * GRID_SIDE + ca];
            plain.plain_second = sq_cell[((rb + GRID_SIDE - 1) % GRID_SIDE) * GRID_SIDE + cb];
          end else begin
            // rectangle: swap columns
            plain.plain_first  = sq_cell[ra * GRID_SIDE + cb];
            plain.plain_second = sq_cell[rb * GRID_SIDE + ca];
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly real letters, now and then a code above Z.
  function automatic letter_t pick_letter();
    if ($urandom_range(0, 7) == 0) return letter_t'($urandom_range(26, 31));
    return letter_t'($urandom_range(0, 25));
  endfunction

  // Offer one item, hold it until taken, then predict its result. Leave
  // valid high afterwards so back-to-back items never toggle it in one step.
  task automatic offer_item(input logic [1:0] m, input letter_t a, input letter_t b,
                            input logic has_typed, input plain_pair_t typed_plain);
    logic        has_plain;
    plain_pair_t plain;
    while (src_gappy && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= m;
    in_first_letter  <= a;
    in_second_letter <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_square(m, a, b, has_plain, plain);
    if (has_plain) expected_plain.push_back(has_typed ? typed_plain : plain);
    if (m != MODE_UNUSED) items_sent++;
  endtask

  // Hold the sender off until every pending result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_plain.size() != 0);
  endtask

  task automatic note_failure(input string what, input plain_pair_t want,
                              input plain_pair_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s at cycle %0d: expected first=%0d second=%0d not_ready=%0b,",
               what, cycle_count, want.plain_first, want.plain_second, want.not_ready);
      $display("  got first=%0d second=%0d not_ready=%0b",
               got.plain_first, got.plain_second, got.not_ready);
    end
  endtask

  // Result side: stall at random, except during the quiet stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= sink_gappy && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Compare each taken result with the oldest pending prediction.
  always @(posedge clk) begin : check_plain
    plain_pair_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_plain_first, out_plain_second, out_not_ready};
      if (expected_plain.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = expected_plain.pop_front();
        if (got.plain_first !== want.plain_first ||
            got.plain_second !== want.plain_second ||
            got.not_ready !== want.not_ready) begin
          note_failure("mismatch", want, got);
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int round;
    int key_len;
    int run_len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(directed_rows); i++) begin
      offer_item(directed_rows[i].mode, directed_rows[i].first_letter,
                 directed_rows[i].second_letter, directed_rows[i].has_typed,
                 directed_rows[i].typed_plain);
    end

    round = 0;
    while (items_sent < ITEM_TARGET) begin
      // Turn idling off on both sides for one long stretch.
      src_gappy  = !(items_sent >= 700 && items_sent < 950);
      sink_gappy = src_gappy;
      if (round == 3 || $urandom_range(0, 19) == 0) drain_results();
      if ($urandom_range(0, 99) < 80) begin
        // Well-formed: a fresh key, finish, then a run of decrypts.
        key_len = $urandom_range(0, 30);
        for (int k = 0; k < key_len; k++) begin
          offer_item(MODE_KEY, pick_letter(), letter_t'($urandom_range(0, 31)), 1'b0, '0);
        end
        offer_item(MODE_FINISH, letter_t'($urandom_range(0, 31)),
                   letter_t'($urandom_range(0, 31)), 1'b0, '0);
        if ($urandom_range(0, 9) == 0) begin
          offer_item(MODE_FINISH, letter_t'($urandom_range(0, 31)),
                     letter_t'($urandom_range(0, 31)), 1'b0, '0);
        end
        run_len = $urandom_range(1, 40);
        for (int k = 0; k < run_len; k++) begin
          offer_item(MODE_DECRYPT, pick_letter(), pick_letter(), 1'b0, '0);
        end
      end else begin
        // Noise: any mode, raw codes, including decrypts on a half-built key.
        run_len = $urandom_range(1, 8);
        for (int k = 0; k < run_len; k++) begin
          offer_item(2'($urandom_range(0, 3)), letter_t'($urandom_range(0, 31)),
                     letter_t'($urandom_range(0, 31)), 1'b0, '0);
        end
      end
      round++;
    end

    src_gappy = 1'b1;
    sink_gappy = 1'b1;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_plain.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: playfair_decrypt_unit.f
rtl/pfd_pkg.sv
rtl/pfd_queue.sv
rtl/pfd_front.sv
rtl/pfd_back.sv
rtl/playfair_decrypt_unit.sv
rtl/pfd_checker.sv
dv/testbench.sv
